FILE: rtl/core/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg
// shared types, codes and helpers of the tiny cpu execute unit
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int REG_COUNT_DEF = 8;
    localparam int MEM_DEPTH_DEF = 64;
    localparam int DATA_W        = 8;
    localparam int WIDE_W        = 17;   // holds every wide add, sub, mul and div result

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = 17'sd127;
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = -17'sd128;
    localparam logic [DATA_W-1:0]        MSB_MASK = 8'h80;
    localparam logic [DATA_W-1:0]        LSB_MASK = 8'h01;

    // flag bit positions
    localparam int FLAG_Z = 0;
    localparam int FLAG_C = 1;
    localparam int FLAG_O = 2;
    localparam int FLAG_U = 3;

    typedef enum logic [3:0] {
        CMD_MOV   = 4'd0,
        CMD_LOAD  = 4'd1,
        CMD_STORE = 4'd2,
        CMD_ADD   = 4'd3,
        CMD_SUB   = 4'd4,
        CMD_MUL   = 4'd5,
        CMD_DIV   = 4'd6,
        CMD_SHL   = 4'd7,
        CMD_SHR   = 4'd8,
        CMD_ROL   = 4'd9,
        CMD_ROR   = 4'd10,
        CMD_INPUT = 4'd11
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_REG = 2'd0,
        MODE_IMM = 2'd1,
        MODE_DIR = 2'd2,
        MODE_IND = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DIV0 = 2'd1,
        STAT_ADDR = 2'd2,
        STAT_MODE = 2'd3
    } stat_code_t;

    // how the result value gets its final byte
    typedef enum logic [1:0] {
        PATH_DIRECT = 2'd0,
        PATH_MEM    = 2'd1,
        PATH_DIV    = 2'd2
    } path_t;

    // how flags are formed at commit
    typedef enum logic [1:0] {
        FM_KEEP  = 2'd0,
        FM_VALUE = 2'd1,
        FM_WIDE  = 2'd2,
        FM_SHIFT = 2'd3
    } fmode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_CAP_B,
        S_EVAL,
        S_MEM,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [3:0]        cmd;
        logic [2:0]        reg_a;
        logic [2:0]        reg_b;
        logic [1:0]        operand_mode;
        logic signed [7:0] immediate;
        logic [7:0]        direct_address;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [7:0] reg_value;
        logic              zero_flag;
        logic              carry_flag;
        logic              overflow_flag;
        logic              underflow_flag;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic cap_item;
        logic rd_sel_b;
        logic cap_a;
        logic cap_b;
        logic eval;
        logic mem_cap;
        logic div_cap;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        path_t path;
        logic  div_done;
    } dp_stat_t;

    function automatic logic signed [WIDE_W-1:0] sext8(input logic [DATA_W-1:0] v);
        return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage

FILE: rtl/core/tiny_cpu_execute_unit_core.sv
// ----------------------------------------------------------------------------
// tiny_cpu_execute_unit_core
// execute unit of a small 8-bit machine: one decoded instruction per word
// ----------------------------------------------------------------------------
// Takes one instruction word at a time and returns one result word for it.
// A plain instruction goes through acceptance, two register file reads
// through its single registered read port, operand capture, evaluate and
// commit; indirect or direct loads add a wait for the registered data memory
// read, and DIV waits for the divider, which retires one quotient bit per
// cycle over 8 steps. The next word is accepted in the
// cycle after a result is committed to the output register, even while that
// result is still waiting for m_ready. Register file and data memory both
// read as zero after reset through per-entry valid bits, so there is no
// clearing pass.
module tiny_cpu_execute_unit_core #(
    parameter int REG_COUNT = tce_pkg::REG_COUNT_DEF,
    parameter int MEM_DEPTH = tce_pkg::MEM_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // instruction words
    input  logic               s_valid,
    output logic               s_ready,
    input  tce_pkg::in_word_t  s_data,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output tce_pkg::out_word_t m_data
);

    // controller to datapath commands and datapath status back
    tce_pkg::dp_cmd_t  dp_cmd;
    tce_pkg::dp_stat_t dp_stat;

    // sequencer: walks read, evaluate, optional memory or divide wait, commit
    tce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    // storage, alu, divider and the output word register
    tce_datapath #(
        .REG_COUNT (REG_COUNT),
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (dp_cmd),
        .stat    (dp_stat),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/core/tce_ram.sv
// ----------------------------------------------------------------------------
// tce_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: rtl/core/tce_div.sv
// ----------------------------------------------------------------------------
// tce_div
// signed 8-bit radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tce_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic signed [7:0] dividend,
    input  logic signed [7:0] divisor,
    output logic              done,
    output logic signed [8:0] quotient
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] dq_reg, dq_next;
    logic [7:0] dvs_reg, dvs_next;
    logic       neg_reg, neg_next;

    logic [8:0] shifted;
    logic [8:0] trial;

    assign shifted = {rem_reg, dq_reg[7]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = dividend[7] ? 8'(-dividend) : dividend;
            dvs_next  = divisor[7] ? 8'(-divisor) : divisor;
            neg_next  = dividend[7] ^ divisor[7];
        end else if (busy_reg) begin
            // shifted < 2*divisor, so the kept remainder stays below 128
            if (!trial[8]) begin
                rem_next = trial[7:0];
                dq_next  = {dq_reg[6:0], 1'b1};
            end else begin
                rem_next = shifted[7:0];
                dq_next  = {dq_reg[6:0], 1'b0};
            end
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});

endmodule

FILE: rtl/core/tce_datapath.sv
// ----------------------------------------------------------------------------
// tce_datapath
// register file, data memory, alu, divider and result register
// ----------------------------------------------------------------------------
module tce_datapath #(
    parameter int REG_COUNT = tce_pkg::REG_COUNT_DEF,
    parameter int MEM_DEPTH = tce_pkg::MEM_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tce_pkg::in_word_t  s_data,
    input  tce_pkg::dp_cmd_t   cmd,
    output tce_pkg::dp_stat_t  stat,
    output tce_pkg::out_word_t m_data
);

    localparam int RIW = $clog2(REG_COUNT);
    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int W   = tce_pkg::WIDE_W;

    tce_pkg::in_word_t         item_reg;
    logic [7:0]                a_reg;
    logic [7:0]                b_reg;
    logic [3:0]                flags_reg;
    logic [1:0]                status_reg;
    logic signed [W-1:0]       wide_reg;
    tce_pkg::fmode_t           fmode_reg;
    logic                      c_reg;
    logic                      wr_rf_reg;
    logic                      wr_mem_reg;
    logic [AW-1:0]             maddr_reg;
    tce_pkg::out_word_t        out_reg;

    logic [REG_COUNT-1:0]      rf_vld_reg;
    logic [MEM_DEPTH-1:0]      mem_vld_reg;
    logic                      rf_vq_reg;
    logic                      mem_vq_reg;

    // register index wraps modulo the register count
    function automatic logic [RIW-1:0] wrap_idx(input logic [2:0] v);
        logic [4:0] r;
        r = {2'b00, v};
        for (int k = 0; k < 3; k++) begin
            if (r >= 5'(REG_COUNT)) begin
                r = r - 5'(REG_COUNT);
            end
        end
        return r[RIW-1:0];
    endfunction

    logic [RIW-1:0] ra_idx, rb_idx, rf_raddr;
    logic [7:0]     rf_rdata, rf_rd;
    logic [7:0]     mem_rdata, mem_rd;
    logic           rf_we, mem_we;

    assign ra_idx   = wrap_idx(item_reg.reg_a);
    assign rb_idx   = wrap_idx(item_reg.reg_b);
    assign rf_raddr = cmd.rd_sel_b ? rb_idx : ra_idx;
    assign rf_rd    = rf_vq_reg ? rf_rdata : '0;
    assign mem_rd   = mem_vq_reg ? mem_rdata : '0;
    assign rf_we    = cmd.commit && wr_rf_reg;
    assign mem_we   = cmd.commit && wr_mem_reg;

    // evaluation
    logic [7:0]           ev_addr8;
    logic [AW-1:0]        ev_maddr;
    logic                 ev_in_range;
    logic signed [7:0]    a_s, src_s;
    logic signed [15:0]   prod;
    logic [7:0]           sh_v;
    logic                 sh_c;
    logic [1:0]           ev_status;
    tce_pkg::path_t       ev_path;
    logic                 ev_wr_rf, ev_wr_mem, ev_c;
    tce_pkg::fmode_t      ev_fmode;
    logic signed [W-1:0]  ev_wide;

    assign ev_addr8    = (item_reg.operand_mode == tce_pkg::MODE_DIR) ?
                         item_reg.direct_address : b_reg;
    assign ev_maddr    = ev_addr8[AW-1:0];
    assign ev_in_range = {1'b0, ev_addr8} < 9'(MEM_DEPTH);
    assign a_s         = $signed(a_reg);
    assign src_s       = (item_reg.operand_mode == tce_pkg::MODE_REG) ?
                         $signed(b_reg) : item_reg.immediate;
    assign prod        = a_s * src_s;

    always_comb begin
        sh_v = a_reg;
        sh_c = 1'b0;
        unique case (item_reg.cmd)
            tce_pkg::CMD_SHL: begin
                sh_c = (a_reg & tce_pkg::MSB_MASK) != '0;
                sh_v = {a_reg[6:0], 1'b0};
            end
            tce_pkg::CMD_SHR: begin
                sh_c = (a_reg & tce_pkg::LSB_MASK) != '0;
                sh_v = {1'b0, a_reg[7:1]};
            end
            tce_pkg::CMD_ROL: begin
                sh_c = (a_reg & tce_pkg::MSB_MASK) != '0;
                sh_v = {a_reg[6:0], a_reg[7]};
            end
            tce_pkg::CMD_ROR: begin
                sh_c = (a_reg & tce_pkg::LSB_MASK) != '0;
                sh_v = {a_reg[0], a_reg[7:1]};
            end
            default: begin
                sh_v = a_reg;
                sh_c = 1'b0;
            end
        endcase
    end

    always_comb begin
        ev_status = tce_pkg::STAT_OK;
        ev_path   = tce_pkg::PATH_DIRECT;
        ev_wr_rf  = 1'b0;
        ev_wr_mem = 1'b0;
        ev_fmode  = tce_pkg::FM_KEEP;
        ev_wide   = tce_pkg::sext8(a_reg);
        ev_c      = 1'b0;
        unique case (item_reg.cmd)
            tce_pkg::CMD_MOV: begin
                unique case (item_reg.operand_mode)
                    tce_pkg::MODE_DIR: ev_status = tce_pkg::STAT_MODE;
                    tce_pkg::MODE_IND: begin
                        if (!ev_in_range) begin
                            ev_status = tce_pkg::STAT_ADDR;
                        end else begin
                            ev_path  = tce_pkg::PATH_MEM;
                            ev_wr_rf = 1'b1;
                            ev_fmode = tce_pkg::FM_VALUE;
                        end
                    end
                    default: begin
                        ev_wr_rf = 1'b1;
                        ev_fmode = tce_pkg::FM_VALUE;
                        ev_wide  = (item_reg.operand_mode == tce_pkg::MODE_REG) ?
                                   tce_pkg::sext8(b_reg) :
                                   tce_pkg::sext8(item_reg.immediate);
                    end
                endcase
            end
            tce_pkg::CMD_LOAD, tce_pkg::CMD_STORE: begin
                if (item_reg.operand_mode == tce_pkg::MODE_REG ||
                    item_reg.operand_mode == tce_pkg::MODE_IMM) begin
                    ev_status = tce_pkg::STAT_MODE;
                end else if (!ev_in_range) begin
                    ev_status = tce_pkg::STAT_ADDR;
                end else if (item_reg.cmd == tce_pkg::CMD_LOAD) begin
                    ev_path  = tce_pkg::PATH_MEM;
                    ev_wr_rf = 1'b1;
                    ev_fmode = tce_pkg::FM_VALUE;
                end else begin
                    ev_wr_mem = 1'b1;
                    ev_fmode  = tce_pkg::FM_VALUE;
                end
            end
            tce_pkg::CMD_ADD, tce_pkg::CMD_SUB, tce_pkg::CMD_MUL, tce_pkg::CMD_DIV: begin
                if (item_reg.operand_mode == tce_pkg::MODE_DIR ||
                    item_reg.operand_mode == tce_pkg::MODE_IND) begin
                    ev_status = tce_pkg::STAT_MODE;
                end else begin
                    ev_wr_rf = 1'b1;
                    ev_fmode = tce_pkg::FM_WIDE;
                    priority case (item_reg.cmd)
                        tce_pkg::CMD_ADD:
                            ev_wide = tce_pkg::sext8(a_reg) + tce_pkg::sext8(src_s);
                        tce_pkg::CMD_SUB:
                            ev_wide = tce_pkg::sext8(a_reg) - tce_pkg::sext8(src_s);
                        tce_pkg::CMD_MUL:
                            ev_wide = {prod[15], prod};
                        default: begin
                            if (src_s == 8'sd0) begin
                                ev_status = tce_pkg::STAT_DIV0;
                                ev_wr_rf  = 1'b0;
                                ev_fmode  = tce_pkg::FM_KEEP;
                            end else begin
                                ev_path = tce_pkg::PATH_DIV;
                            end
                        end
                    endcase
                end
            end
            tce_pkg::CMD_SHL, tce_pkg::CMD_SHR, tce_pkg::CMD_ROL, tce_pkg::CMD_ROR: begin
                ev_wr_rf = 1'b1;
                ev_fmode = tce_pkg::FM_SHIFT;
                ev_wide  = tce_pkg::sext8(sh_v);
                ev_c     = sh_c;
            end
            tce_pkg::CMD_INPUT: begin
                ev_wr_rf = 1'b1;
                ev_fmode = tce_pkg::FM_VALUE;
                ev_wide  = tce_pkg::sext8(item_reg.immediate);
            end
            default: begin
                // display: nothing changes
                ev_status = tce_pkg::STAT_OK;
            end
        endcase
    end

    // divider
    logic              div_done;
    logic signed [8:0] div_q;

    tce_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.eval && (ev_path == tce_pkg::PATH_DIV)),
        .dividend (a_s),
        .divisor  (src_s),
        .done     (div_done),
        .quotient (div_q)
    );

    assign stat.path     = ev_path;
    assign stat.div_done = div_done;

    // storage
    tce_ram #(.WIDTH(8), .DEPTH(REG_COUNT)) u_rf (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (ra_idx),
        .wdata (wide_reg[7:0]),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    tce_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (maddr_reg),
        .wdata (a_reg),
        .raddr (ev_maddr),
        .rdata (mem_rdata)
    );

    // commit: final byte and flags
    logic [7:0] res_byte;
    logic [3:0] fl_next;
    logic       res_z, res_o, res_u;

    assign res_byte = wide_reg[7:0];
    assign res_z    = (res_byte == '0);
    assign res_o    = (wide_reg > tce_pkg::WIDE_MAX);
    assign res_u    = (wide_reg < tce_pkg::WIDE_MIN);

    always_comb begin
        fl_next = flags_reg;
        unique case (fmode_reg)
            tce_pkg::FM_KEEP:  fl_next = flags_reg;
            tce_pkg::FM_VALUE: fl_next = {3'b000, res_z};
            tce_pkg::FM_WIDE:  fl_next = {res_u, res_o, res_o | res_u, res_z};
            tce_pkg::FM_SHIFT: fl_next = {2'b00, c_reg, res_z};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg   <= '0;
            rf_vld_reg  <= '0;
            mem_vld_reg <= '0;
        end else if (cmd.commit) begin
            flags_reg <= fl_next;
            if (rf_we) begin
                rf_vld_reg[ra_idx] <= 1'b1;
            end
            if (mem_we) begin
                mem_vld_reg[maddr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rf_vq_reg  <= rf_vld_reg[rf_raddr];
        mem_vq_reg <= mem_vld_reg[ev_maddr];
        if (cmd.cap_item) begin
            item_reg <= s_data;
        end
        if (cmd.cap_a) begin
            a_reg <= rf_rd;
        end
        if (cmd.cap_b) begin
            b_reg <= rf_rd;
        end
        if (cmd.eval) begin
            status_reg <= ev_status;
            wide_reg   <= ev_wide;
            fmode_reg  <= ev_fmode;
            c_reg      <= ev_c;
            wr_rf_reg  <= ev_wr_rf;
            wr_mem_reg <= ev_wr_mem;
            maddr_reg  <= ev_maddr;
        end
        if (cmd.mem_cap) begin
            wide_reg <= tce_pkg::sext8(mem_rd);
        end
        if (cmd.div_cap) begin
            wide_reg <= {{(W-9){div_q[8]}}, div_q};
        end
        if (cmd.commit) begin
            out_reg.status         <= status_reg;
            out_reg.reg_value      <= $signed(res_byte);
            out_reg.zero_flag      <= fl_next[tce_pkg::FLAG_Z];
            out_reg.carry_flag     <= fl_next[tce_pkg::FLAG_C];
            out_reg.overflow_flag  <= fl_next[tce_pkg::FLAG_O];
            out_reg.underflow_flag <= fl_next[tce_pkg::FLAG_U];
        end
    end

    assign m_data = out_reg;

endmodule

FILE: rtl/core/tce_ctrl.sv
// ----------------------------------------------------------------------------
// tce_ctrl
// sequencing state machine and output valid register
// ----------------------------------------------------------------------------
module tce_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  tce_pkg::dp_stat_t stat,
    output tce_pkg::dp_cmd_t  cmd
);

    tce_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tce_pkg::S_IDLE:  if (s_valid) state_next = tce_pkg::S_RD_A;
            tce_pkg::S_RD_A:  state_next = tce_pkg::S_RD_B;
            tce_pkg::S_RD_B:  state_next = tce_pkg::S_CAP_B;
            tce_pkg::S_CAP_B: state_next = tce_pkg::S_EVAL;
            tce_pkg::S_EVAL: begin
                unique case (stat.path)
                    tce_pkg::PATH_MEM: state_next = tce_pkg::S_MEM;
                    tce_pkg::PATH_DIV: state_next = tce_pkg::S_DIV;
                    default:           state_next = tce_pkg::S_DONE;
                endcase
            end
            tce_pkg::S_MEM:   state_next = tce_pkg::S_DONE;
            tce_pkg::S_DIV:   if (stat.div_done) state_next = tce_pkg::S_DONE;
            tce_pkg::S_DONE:  if (slot_free) state_next = tce_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            tce_pkg::S_IDLE: begin
                s_ready      = 1'b1;
                cmd.cap_item = s_valid;
            end
            tce_pkg::S_RD_A:  cmd.rd_sel_b = 1'b0;
            tce_pkg::S_RD_B: begin
                cmd.rd_sel_b = 1'b1;
                cmd.cap_a    = 1'b1;
            end
            tce_pkg::S_CAP_B: cmd.cap_b   = 1'b1;
            tce_pkg::S_EVAL:  cmd.eval    = 1'b1;
            tce_pkg::S_MEM:   cmd.mem_cap = 1'b1;
            tce_pkg::S_DIV:   cmd.div_cap = stat.div_done;
            tce_pkg::S_DONE:  cmd.commit  = slot_free;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tce_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/core/tce_checker.sv
// ----------------------------------------------------------------------------
// tce_checker
// port level checks on the execute unit, bound to the top level
// ----------------------------------------------------------------------------
module tce_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input tce_pkg::in_word_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input tce_pkg::out_word_t m_data
);

    logic       s_acc, m_acc;
    logic [1:0] pend_reg;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    // words in flight: one being worked on plus one waiting at the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 2'(s_acc) - 2'(m_acc);
        end
    end

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // one instruction at a time: no acceptance right after an acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_ready)
        else $error("input accepted back to back");

    // never more than two words in flight, and no result without an instruction
    a_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != 2'd3) && (!m_valid || (pend_reg != 2'd0)))
        else $error("result count does not match accepted instructions");

    // carry accompanies overflow or underflow, which never both hold
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.overflow_flag || m_data.underflow_flag) |->
            m_data.carry_flag && !(m_data.overflow_flag && m_data.underflow_flag))
        else $error("inconsistent arithmetic flags");

    // an offered instruction word is held until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

endmodule

bind tiny_cpu_execute_unit_core tce_checker u_chk (.*);
